### design/cpfq_pkg.sv
package cpfq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int CLASS_COUNT = 3;

   localparam int IDENT_W = 32;
   localparam int LABEL_W = 32;
   localparam int CLASS_W = 2;
   localparam int STATUS_W = 2;
   localparam int OCC_W = 5;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_SERVE = 1'b1;

   localparam logic [STATUS_W-1:0] RSP_INSERTED = 2'd0;
   localparam logic [STATUS_W-1:0] RSP_SERVED = 2'd1;
   localparam logic [STATUS_W-1:0] RSP_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] RSP_FULL = 2'd3;

   localparam logic [CLASS_W-1:0] CLASS_LAST = CLASS_W'(CLASS_COUNT - 1);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic do_insert;
      logic do_serve;
      logic capture;
      logic [STATUS_W-1:0] rsp_code;
   } ctrl_cmd_type;

   // Queue status from the datapath to the controller.
   typedef struct packed {
      logic full;
      logic empty;
   } dp_status_type;

endpackage

### design/cpfq_if.sv
interface cpfq_req_if;
   logic valid;
   logic ready;
   logic cmd;
   logic signed [31:0] entry_ident;
   logic [31:0] entry_label;
   logic [1:0] entry_class;

   modport source (output valid, output cmd, output entry_ident, output entry_label,
                   output entry_class, input ready);
   modport sink (input valid, input cmd, input entry_ident, input entry_label,
                 input entry_class, output ready);
endinterface

interface cpfq_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] status;
   logic signed [31:0] served_ident;
   logic [31:0] served_label;
   logic [1:0] served_class;
   logic [4:0] occupancy;

   modport source (output valid, output status, output served_ident, output served_label,
                   output served_class, output occupancy, input ready);
   modport sink (input valid, input status, input served_ident, input served_label,
                 input served_class, input occupancy, output ready);
endinterface

### design/class_priority_fifo_queue.sv
// Class priority queue, first in, first out within each class.
//
// Beats arrive on req_if (valid/ready). A beat with cmd insert carries an
// identifier, a name tag and a priority class (0 most urgent); the entry is
// placed behind every held entry of the same or a more urgent class. A beat
// with cmd serve removes the head entry. Classes beyond the last one are
// stored as the least urgent class.
// Every request beat gives exactly one response beat on rsp_if: inserted,
// served (with the entry's fields), serve on an empty queue, or insert dropped
// because all QUEUE_DEPTH slots are full. The occupancy after the step is
// reported with every response.
// The response is registered and is shown in the cycle after the request
// beat. Throughput is one beat per cycle; the slot chain compares every slot's
// class against the new entry in parallel and shifts all slots together, and
// the single response register sets the pace when rsp_if stalls: while a
// response waits, a new request is taken only in the cycle in which the
// waiting response is taken.
// Reset (synchronous, active high) empties the queue and drops any pending
// response; slot contents are not cleared and are never read while empty.
module class_priority_fifo_queue (
   input logic clock,
   input logic reset,
   cpfq_req_if.sink req_if,
   cpfq_rsp_if.source rsp_if
);
   import cpfq_pkg::*;

   ctrl_cmd_type ctrl_cmd;
   dp_status_type dp_status;
   logic [FILL_W-1:0] fill_count;

   // The controller owns the handshakes and decides what the step does.
   cpfq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_cmd   (req_if.cmd),
      .req_ready (req_if.ready),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .dp_status (dp_status),
      .ctrl_cmd  (ctrl_cmd)
   );

   // The datapath holds the sorted slots, the fill count and the response register.
   cpfq_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctrl_cmd      (ctrl_cmd),
      .dp_status     (dp_status),
      .fill_count    (fill_count),
      .new_ident     (req_if.entry_ident),
      .new_label     (req_if.entry_label),
      .new_class     (req_if.entry_class),
      .out_status    (rsp_if.status),
      .out_ident     (rsp_if.served_ident),
      .out_label     (rsp_if.served_label),
      .out_class     (rsp_if.served_class),
      .out_occupancy (rsp_if.occupancy)
   );

   // The fill count never passes the queue depth.
   assert property (@(posedge clock) disable iff (reset)
      fill_count <= FILL_W'(QUEUE_DEPTH))
      else $error("fill count beyond queue depth");

   // An insert taken on a full queue is answered as dropped.
   assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && req_if.cmd == CMD_INSERT && dp_status.full)
      |=> (rsp_if.valid && rsp_if.status == RSP_FULL))
      else $error("insert on full queue not reported as dropped");

   // A serve on an empty queue reports zero occupancy.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status == RSP_EMPTY) |-> (rsp_if.occupancy == '0))
      else $error("empty response with nonzero occupancy");

   // Only a served entry carries payload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status != RSP_SERVED) |->
      (rsp_if.served_ident == '0 && rsp_if.served_label == '0 && rsp_if.served_class == '0))
      else $error("payload on a response without a served entry");

endmodule

### design/cpfq_ctrl.sv
module cpfq_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_cmd,
   output logic req_ready,
   input  logic rsp_ready,
   output logic rsp_valid,
   input  cpfq_pkg::dp_status_type dp_status,
   output cpfq_pkg::ctrl_cmd_type ctrl_cmd
);
   import cpfq_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_HOLD = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;

   // A new beat is taken whenever the result register is free or being emptied.
   assign req_ready = (state_ff == S_IDLE) || rsp_ready;
   assign rsp_valid = (state_ff == S_HOLD);
   assign accept = req_valid && req_ready;

   always_comb begin
      ctrl_cmd = '0;
      ctrl_cmd.capture = accept;
      if (req_cmd == CMD_INSERT) begin
         ctrl_cmd.do_insert = accept && !dp_status.full;
         ctrl_cmd.rsp_code = dp_status.full ? RSP_FULL : RSP_INSERTED;
      end else begin
         ctrl_cmd.do_serve = accept && !dp_status.empty;
         ctrl_cmd.rsp_code = dp_status.empty ? RSP_EMPTY : RSP_SERVED;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_HOLD;
         end
         S_HOLD: begin
            if (!accept && rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### design/cpfq_dp.sv
module cpfq_dp (
   input  logic clock,
   input  logic reset,
   input  cpfq_pkg::ctrl_cmd_type ctrl_cmd,
   output cpfq_pkg::dp_status_type dp_status,
   output logic [cpfq_pkg::FILL_W-1:0] fill_count,
   input  logic signed [cpfq_pkg::IDENT_W-1:0] new_ident,
   input  logic [cpfq_pkg::LABEL_W-1:0] new_label,
   input  logic [cpfq_pkg::CLASS_W-1:0] new_class,
   output logic [cpfq_pkg::STATUS_W-1:0] out_status,
   output logic signed [cpfq_pkg::IDENT_W-1:0] out_ident,
   output logic [cpfq_pkg::LABEL_W-1:0] out_label,
   output logic [cpfq_pkg::CLASS_W-1:0] out_class,
   output logic [cpfq_pkg::OCC_W-1:0] out_occupancy
);
   import cpfq_pkg::*;

   logic signed [IDENT_W-1:0] slot_ident_ff [QUEUE_DEPTH];
   logic [LABEL_W-1:0] slot_label_ff [QUEUE_DEPTH];
   logic [CLASS_W-1:0] slot_class_ff [QUEUE_DEPTH];
   logic signed [IDENT_W-1:0] slot_ident_in [QUEUE_DEPTH];
   logic [LABEL_W-1:0] slot_label_in [QUEUE_DEPTH];
   logic [CLASS_W-1:0] slot_class_in [QUEUE_DEPTH];
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic [QUEUE_DEPTH-1:0] stays;
   logic [CLASS_W-1:0] ins_class;

   logic [STATUS_W-1:0] status_ff;
   logic signed [IDENT_W-1:0] ident_ff;
   logic [LABEL_W-1:0] label_ff;
   logic [CLASS_W-1:0] class_ff;
   logic [OCC_W-1:0] occ_ff;

   // Out-of-range classes are treated as least urgent.
   assign ins_class = (new_class > CLASS_LAST) ? CLASS_LAST : new_class;

   assign dp_status.full = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign dp_status.empty = (fill_ff == '0);
   assign fill_count = fill_ff;

   // Each held slot whose class is no less urgent than the new entry keeps its place.
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         stays[i] = (FILL_W'(i) < fill_ff) && (slot_class_ff[i] <= ins_class);
      end
   end

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         slot_ident_in[i] = slot_ident_ff[i];
         slot_label_in[i] = slot_label_ff[i];
         slot_class_in[i] = slot_class_ff[i];
         if (ctrl_cmd.do_insert && !stays[i]) begin
            if (i == 0 || stays[(i == 0) ? 0 : i - 1]) begin
               slot_ident_in[i] = new_ident;
               slot_label_in[i] = new_label;
               slot_class_in[i] = ins_class;
            end else begin
               slot_ident_in[i] = slot_ident_ff[(i == 0) ? 0 : i - 1];
               slot_label_in[i] = slot_label_ff[(i == 0) ? 0 : i - 1];
               slot_class_in[i] = slot_class_ff[(i == 0) ? 0 : i - 1];
            end
         end else if (ctrl_cmd.do_serve && i < QUEUE_DEPTH - 1) begin
            slot_ident_in[i] = slot_ident_ff[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            slot_label_in[i] = slot_label_ff[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            slot_class_in[i] = slot_class_ff[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
         end
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (ctrl_cmd.do_insert) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (ctrl_cmd.do_serve) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         slot_ident_ff[i] <= slot_ident_in[i];
         slot_label_ff[i] <= slot_label_in[i];
         slot_class_ff[i] <= slot_class_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.capture) begin
         status_ff <= ctrl_cmd.rsp_code;
         ident_ff <= ctrl_cmd.do_serve ? slot_ident_ff[0] : '0;
         label_ff <= ctrl_cmd.do_serve ? slot_label_ff[0] : '0;
         class_ff <= ctrl_cmd.do_serve ? slot_class_ff[0] : '0;
         occ_ff <= OCC_W'(fill_in);
      end
   end

   assign out_status = status_ff;
   assign out_ident = ident_ff;
   assign out_label = label_ff;
   assign out_class = class_ff;
   assign out_occupancy = occ_ff;

endmodule
